// ===== hw/rtl/isort_pkg.sv =====
// isort_pkg: shared types and constants for the insertion sorter
// holds transfer payload structs and controller/datapath command and status types
// no dependencies
`timescale 1ns / 1ps

package isort_pkg;

    localparam int SIZE_DEF = 64;
    localparam int VAL_W    = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    last_out;
        logic                    overflow;
    } out_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic one_left;
    } sts_t;

endpackage

// ===== hw/rtl/isort_dp.sv =====
// isort_dp: row of sorted cells with parallel compare-and-shift, fill count,
// drop flag and output payload register
// depends on isort_pkg
`timescale 1ns / 1ps

module isort_dp #(
    parameter int SIZE = isort_pkg::SIZE_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  isort_pkg::cmd_t                       cmd,
    input  logic signed [isort_pkg::VAL_W-1:0]    in_value,
    output isort_pkg::out_t                       out_data,
    output isort_pkg::sts_t                       sts
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(SIZE + 1);

    logic signed [VAL_W-1:0] cell_reg [SIZE];
    logic        [SIZE-1:0]  move;
    logic        [CNT_W-1:0] count_reg;
    logic        [CNT_W-1:0] count_next;
    logic                    drop_reg;
    logic                    drop_next;
    logic                    full;
    out_t                    out_reg;

    assign full         = (count_reg == CNT_W'(SIZE));
    assign sts.one_left = (count_reg == CNT_W'(1));
    assign out_data     = out_reg;

    // a valid cell holding a strictly greater value moves one place up
    genvar i;
    generate
        for (i = 0; i < SIZE; i++) begin : g_cell
            assign move[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] > in_value);

            if (i == 0) begin : g_first
                always_ff @(posedge clk)
                begin
                    if (cmd.pop)
                    begin
                        if (SIZE > 1)
                        begin
                            cell_reg[0] <= cell_reg[(SIZE > 1) ? 1 : 0];
                        end
                    end
                    else if (cmd.insert && !full && (count_reg == CNT_W'(0) || move[0]))
                    begin
                        cell_reg[0] <= in_value;
                    end
                end
            end
            else begin : g_rest
                always_ff @(posedge clk)
                begin
                    if (cmd.pop)
                    begin
                        if (i < SIZE - 1)
                        begin
                            cell_reg[i] <= cell_reg[(i < SIZE - 1) ? i + 1 : i];
                        end
                    end
                    else if (cmd.insert && !full
                             && (count_reg == CNT_W'(i) || move[i]))
                    begin
                        cell_reg[i] <= move[i-1] ? cell_reg[i-1] : in_value;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            if (sts.one_left)
            begin
                drop_next = 1'b0;
            end
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    // output payload, loaded from the head cell on each pop
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_reg.sorted_value <= cell_reg[0];
            out_reg.last_out     <= sts.one_left;
            out_reg.overflow     <= drop_reg;
        end
    end

endmodule

// ===== hw/rtl/isort_ctrl.sv =====
// isort_ctrl: fill/emit state machine and output valid handling
// depends on isort_pkg
`timescale 1ns / 1ps

module isort_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  isort_pkg::sts_t sts,
    output isort_pkg::cmd_t cmd
);
    import isort_pkg::*;

    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall   = (state_reg == ST_EMIT);
    assign out_valid  = out_valid_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cmd.insert = in_valid && (state_reg == ST_FILL);
    assign cmd.pop    = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (cmd.pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_FILL:
            begin
                if (cmd.insert && in_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.pop && sts.one_left)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/insertion_sorter_core.sv =====
// insertion_sorter_core: streaming stable insertion sort, one value per transfer.
// fill: one input transfer per cycle, each value placed by a parallel compare-and-shift row.
// emit: the last-marked transfer switches to emission, where each head pop registers one result,
// one per cycle while not stalled; input stalls throughout, one head pop per stored value.
// reset: asynchronous active-low, clears fill count, drop flag, state and output valid;
// cell contents need no clearing since only filled cells are ever read.
`timescale 1ns / 1ps

module insertion_sorter_core #(
    parameter int SIZE = isort_pkg::SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  isort_pkg::in_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output isort_pkg::out_t out_data
);
    import isort_pkg::*;

    // commands from the controller into the cell row, status back
    cmd_t cmd;
    sts_t sts;

    // controller: accepts values while filling, pops the head cell during emission
    isort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: sorted cells, fill count, drop flag and output register
    // a full store drops the value and sets the overflow flag for the run
    isort_dp #(
        .SIZE (SIZE)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_value (in_data.value),
        .out_data (out_data),
        .sts      (sts)
    );

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for insertion_sorter_core, stable streaming sort of signed values
// uses isort_pkg for the payload structs; a scoreboard class predicts every sorted run
`timescale 1ns / 1ps

module tb;

    import isort_pkg::*;

    localparam int ROWS        = SIZE_DEF;
    localparam int RANDOM_GOAL = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 20;

    // keeps its own sorted copy and the queue of runs still owed by the block
    class sort_scoreboard;
        logic signed [VAL_W-1:0] ranked [ROWS];
        int   fill;
        bit   dropped;
        out_t expected_sorted [$];
        int   mismatches;
        int   results_checked;
        int   sets_closed;
        int   overflow_sets;

        function void note_input(in_t item);
            int slot;
            out_t run_entry;
            if (fill >= ROWS)
            begin
                dropped = 1'b1;
            end
            else
            begin
                // move only strictly greater values, so equal ones keep arrival order
                slot = fill;
                while (slot > 0 && $signed(ranked[slot-1]) > $signed(item.value))
                begin
                    ranked[slot] = ranked[slot-1];
                    slot--;
                end
                ranked[slot] = item.value;
                fill++;
            end
            if (item.last)
            begin
                for (int k = 0; k < fill; k++)
                begin
                    run_entry.sorted_value = ranked[k];
                    run_entry.last_out     = (k == fill - 1);
                    run_entry.overflow     = dropped;
                    expected_sorted.push_back(run_entry);
                end
                sets_closed++;
                if (dropped)
                    overflow_sets++;
                fill    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            bit   bad;
            results_checked++;
            if (expected_sorted.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d last %0b overflow %0b",
                             got.sorted_value, got.last_out, got.overflow);
                return;
            end
            want = expected_sorted.pop_front();
            bad  = (got.sorted_value !== want.sorted_value)
                || (got.last_out !== want.last_out)
                || (got.overflow !== want.overflow);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                             want.sorted_value, want.last_out, want.overflow,
                             got.sorted_value, got.last_out, got.overflow);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;

    sort_scoreboard sb = new;

    int  cycles;
    int  items_sent;
    bit  steady;       // when set, neither side inserts idle cycles
    int  failures;

    insertion_sorter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle budget, far above the slowest legal run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // input side: every accepted transfer feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(in_data);
    end

    // output side: random stall, check every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        out_stall <= !steady && ($urandom_range(99) < 19);
    end

    // one input transfer; idles at random first, leaves valid high on exit
    task automatic send_value(input logic signed [VAL_W-1:0] v, input logic is_last);
        while (!steady && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_data.value   <= v;
        in_data.last    <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // drop valid and hold off until every owed result has been seen
    task automatic drain_runs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_sorted.size() != 0);
    endtask

    // flavor 0: full range, 1: narrow band with many ties, 2: extremes and values around zero
    function automatic logic signed [VAL_W-1:0] pick_value(int flavor);
        logic signed [VAL_W-1:0] v;
        case (flavor)
            1:       v = $signed($urandom_range(8)) - 4;
            2:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_set(int count, int flavor);
        for (int i = 0; i < count; i++)
            send_value(pick_value(flavor), i == count - 1);
    endtask

    function automatic int pick_flavor();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 85)
            return 1;
        return 2;
    endfunction

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        steady    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both extremes, zero and neighbors, repeated extremes
        send_value(32'h7fff_ffff, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        send_value(32'h7fff_ffff, 1'b1);
        // one-element sets
        send_value(0, 1'b1);
        send_value(32'h8000_0000, 1'b1);
        // already ascending, strictly descending, ties mixed in
        send_value(1, 1'b0);
        send_value(2, 1'b0);
        send_value(3, 1'b1);
        send_value(5, 1'b0);
        send_value(4, 1'b0);
        send_value(3, 1'b0);
        send_value(2, 1'b1);
        send_value(3, 1'b0);
        send_value(3, 1'b0);
        send_value(-3, 1'b0);
        send_value(3, 1'b1);

        // sender holds back until the whole backlog has come out
        drain_runs();

        // store overflows; the last-marked value is itself dropped
        send_set(ROWS + 2, pick_flavor());
        // exactly full set with no idling anywhere, emission included
        steady = 1'b1;
        send_set(ROWS, pick_flavor());
        drain_runs();
        steady = 1'b0;

        while (items_sent < 20 + RANDOM_GOAL)
            send_set($urandom_range(1, 12), pick_flavor());

        drain_runs();
        repeat (SETTLE) @(posedge clk);

        failures = sb.mismatches + sb.expected_sorted.size();
        $display("sent %0d values in %0d sets (%0d overflowing), checked %0d sorted results",
                 items_sent, sb.sets_closed, sb.overflow_sets, sb.results_checked);
        $display("%0d mismatches in %0d cycles", sb.mismatches, cycles);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
